>>> src/hsrn_pkg.sv
package hsrn_pkg;

    localparam int MAX_RING  = 32;
    localparam int MAX_LEVEL = 10;

    // Fixed field widths
    localparam int IDX_W  = 12;
    localparam int LEV_W  = 4;
    localparam int NIDX_W = 13;

    // Farthest cell from the origin any walk can reach
    localparam int FAR_RING = MAX_RING + MAX_LEVEL;
    localparam int RING_W   = $clog2(FAR_RING + 1);
    localparam int COORD_W  = RING_W + 1;

    // Center index decode
    localparam int LIMIT  = 3 * MAX_RING * (MAX_RING + 1);
    localparam int RN_W   = $clog2(MAX_RING + 1);
    localparam int T_W    = $clog2(LIMIT + 1);
    localparam int CMP_W  = (T_W > IDX_W) ? T_W : IDX_W;
    localparam int OFF_W  = $clog2(6 * MAX_RING);

    // Spiral index rebuild
    localparam int CALC_W   = (2 * RING_W + 2 > NIDX_W) ? 2 * RING_W + 2 : NIDX_W;
    localparam int NIDX_MAX = 3 * FAR_RING * (FAR_RING + 1);

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [RING_W-1:0]         ring_t;
    typedef logic [2:0]                seg_t;
    typedef logic signed [1:0]         dir_t;
    typedef logic [LEV_W-1:0]          lev_t;

    localparam int   NUM_SEG  = 6;
    localparam seg_t LAST_SEG = seg_t'(NUM_SEG - 1);

    localparam dir_t DIR_POS  = 2'sd1;
    localparam dir_t DIR_NEG  = -2'sd1;
    localparam dir_t DIR_ZERO = 2'sd0;

    localparam dir_t DIR_L [NUM_SEG] = '{DIR_ZERO, DIR_NEG, DIR_NEG, DIR_ZERO, DIR_POS, DIR_POS};
    localparam dir_t DIR_K [NUM_SEG] = '{DIR_POS, DIR_POS, DIR_ZERO, DIR_NEG, DIR_NEG, DIR_ZERO};

    typedef struct packed {
        logic [IDX_W-1:0] cell_index;
        lev_t             ring_level;
    } req_t;

    typedef struct packed {
        logic [NIDX_W-1:0] neighbor_index;
        logic              last;
    } res_t;

    // One center cell handed from the decoder to the ring walker
    typedef struct packed {
        coord_t l;
        coord_t k;
        lev_t   lev;
    } cmd_t;

    // c + dv * amt, with dv one of -1, 0, +1
    function automatic coord_t apply_dir(coord_t c, dir_t dv, coord_t amt);
        coord_t r;
        unique case (dv)
            DIR_POS: r = c + amt;
            DIR_NEG: r = c - amt;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic ring_t mag(coord_t v);
        coord_t a;
        a = v[COORD_W-1] ? -v : v;
        return a[RING_W-1:0];
    endfunction

endpackage

>>> src/hsrn_fifo.sv
module hsrn_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  hsrn_pkg::cmd_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            valid,
    output hsrn_pkg::cmd_t  rd_data
);

    hsrn_pkg::cmd_t                   mem_reg [hsrn_pkg::Q_DEPTH];
    logic [hsrn_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [hsrn_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [hsrn_pkg::QCNT_W-1:0]      cnt_reg;
    logic                             do_wr;
    logic                             do_rd;

    assign full    = (cnt_reg == hsrn_pkg::QCNT_W'(hsrn_pkg::Q_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == hsrn_pkg::QPTR_W'(hsrn_pkg::Q_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == hsrn_pkg::QPTR_W'(hsrn_pkg::Q_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/hsrn_front.sv
module hsrn_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  hsrn_pkg::req_t  item,
    output logic            q_push,
    output hsrn_pkg::cmd_t  q_data,
    input  logic            q_full
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RING,
        ST_SEG,
        ST_PUSH
    } state_t;

    state_t                          state_reg;
    logic [hsrn_pkg::IDX_W-1:0]      idx_reg;
    hsrn_pkg::lev_t                  lev_reg;
    logic [hsrn_pkg::RN_W-1:0]       n_reg;
    logic [hsrn_pkg::CMP_W-1:0]      t_reg;    // 3n(n+1), last index of ring n
    logic [hsrn_pkg::OFF_W-1:0]      off_reg;
    hsrn_pkg::seg_t                  seg_reg;
    hsrn_pkg::coord_t                cl_reg;
    hsrn_pkg::coord_t                ck_reg;

    logic                            drop;
    logic [hsrn_pkg::CMP_W-1:0]      idx_c;
    logic [hsrn_pkg::CMP_W-1:0]      n_c;
    logic [hsrn_pkg::CMP_W-1:0]      np1_c;
    logic [hsrn_pkg::CMP_W-1:0]      t_inc;
    logic [hsrn_pkg::CMP_W-1:0]      off_full;
    hsrn_pkg::coord_t                nc;
    hsrn_pkg::coord_t                p1c;

    assign drop = (item.ring_level == '0)
               || (item.ring_level > hsrn_pkg::LEV_W'(hsrn_pkg::MAX_LEVEL))
               || (32'(item.cell_index) > 32'(hsrn_pkg::LIMIT));

    assign idx_c    = hsrn_pkg::CMP_W'(idx_reg);
    assign n_c      = hsrn_pkg::CMP_W'(n_reg);
    assign np1_c    = n_c + 1'b1;
    assign t_inc    = (np1_c << 2) + (np1_c << 1);
    // idx - 1 - 3n(n-1), with 3n(n-1) = t - 6n
    assign off_full = idx_c - 1'b1 - t_reg + (n_c << 2) + (n_c << 1);
    assign nc       = hsrn_pkg::coord_t'(n_reg);
    assign p1c      = hsrn_pkg::coord_t'(off_reg) + 1'b1;

    assign full   = (state_reg != ST_IDLE);
    assign q_push = (state_reg == ST_PUSH);
    assign q_data = '{l: cl_reg, k: ck_reg, lev: lev_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            lev_reg   <= '0;
            n_reg     <= '0;
            t_reg     <= '0;
            off_reg   <= '0;
            seg_reg   <= '0;
            cl_reg    <= '0;
            ck_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (push && !drop)
                    begin
                        idx_reg <= item.cell_index;
                        lev_reg <= item.ring_level;
                        if (item.cell_index == '0)
                        begin
                            cl_reg    <= '0;
                            ck_reg    <= '0;
                            state_reg <= ST_PUSH;
                        end
                        else
                        begin
                            n_reg     <= hsrn_pkg::RN_W'(1);
                            t_reg     <= hsrn_pkg::CMP_W'(6);
                            state_reg <= ST_RING;
                        end
                    end
                end
                ST_RING:
                begin
                    // one ring per cycle until the ring's last index reaches idx
                    if (t_reg < idx_c)
                    begin
                        n_reg <= n_reg + 1'b1;
                        t_reg <= t_reg + t_inc;
                    end
                    else
                    begin
                        off_reg   <= off_full[hsrn_pkg::OFF_W-1:0];
                        seg_reg   <= '0;
                        cl_reg    <= nc;
                        ck_reg    <= -nc;
                        state_reg <= ST_SEG;
                    end
                end
                ST_SEG:
                begin
                    // one full side per cycle, then the partial step on the final side
                    if (off_reg >= hsrn_pkg::OFF_W'(n_reg) && seg_reg != hsrn_pkg::LAST_SEG)
                    begin
                        off_reg <= off_reg - hsrn_pkg::OFF_W'(n_reg);
                        cl_reg  <= hsrn_pkg::apply_dir(cl_reg, hsrn_pkg::DIR_L[seg_reg], nc);
                        ck_reg  <= hsrn_pkg::apply_dir(ck_reg, hsrn_pkg::DIR_K[seg_reg], nc);
                        seg_reg <= seg_reg + 1'b1;
                    end
                    else
                    begin
                        cl_reg    <= hsrn_pkg::apply_dir(cl_reg, hsrn_pkg::DIR_L[seg_reg], p1c);
                        ck_reg    <= hsrn_pkg::apply_dir(ck_reg, hsrn_pkg::DIR_K[seg_reg], p1c);
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/hsrn_back.sv
module hsrn_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  hsrn_pkg::cmd_t  q_data,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output hsrn_pkg::res_t  result
);

    // Walker
    logic                    busy_reg;
    hsrn_pkg::coord_t        l_reg;
    hsrn_pkg::coord_t        k_reg;
    hsrn_pkg::seg_t          d_reg;
    hsrn_pkg::lev_t          s_reg;
    hsrn_pkg::lev_t          lev_reg;

    // Stage 1: visited cell
    logic                    v1_reg;
    hsrn_pkg::coord_t        l1_reg;
    hsrn_pkg::coord_t        k1_reg;
    logic                    last1_reg;

    // Stage 2: ring, side and position
    logic                    v2_reg;
    hsrn_pkg::ring_t         ring2_reg;
    hsrn_pkg::seg_t          seg2_reg;
    hsrn_pkg::ring_t         along2_reg;
    logic                    zero2_reg;
    logic                    last2_reg;

    // Stage 3: result register
    logic                    out_valid_reg;
    hsrn_pkg::res_t          out_reg;

    logic                    en;
    logic                    side_end;
    logic                    walk_last;
    hsrn_pkg::coord_t        l_step;
    hsrn_pkg::coord_t        k_step;
    hsrn_pkg::coord_t        lev_c;

    hsrn_pkg::coord_t        sum1;
    hsrn_pkg::ring_t         ml;
    hsrn_pkg::ring_t         mk;
    hsrn_pkg::ring_t         ms;
    hsrn_pkg::ring_t         ring_c;
    hsrn_pkg::seg_t          seg_c;
    hsrn_pkg::ring_t         along_c;

    logic [hsrn_pkg::CALC_W-1:0] rc;
    logic [hsrn_pkg::CALC_W-1:0] rr;
    logic [hsrn_pkg::CALC_W-1:0] idx_calc;

    assign en     = !out_valid_reg || pop;
    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign q_pop  = en && !busy_reg && q_valid;

    assign side_end  = (s_reg + 1'b1 == lev_reg);
    assign walk_last = side_end && (d_reg == hsrn_pkg::LAST_SEG);
    assign l_step    = hsrn_pkg::apply_dir(l_reg, hsrn_pkg::DIR_L[d_reg], hsrn_pkg::coord_t'(1));
    assign k_step    = hsrn_pkg::apply_dir(k_reg, hsrn_pkg::DIR_K[d_reg], hsrn_pkg::coord_t'(1));
    assign lev_c     = hsrn_pkg::coord_t'(q_data.lev);

    // Axial to spiral, first half
    always_comb
    begin
        sum1 = l1_reg + k1_reg;
        ml   = hsrn_pkg::mag(l1_reg);
        mk   = hsrn_pkg::mag(k1_reg);
        ms   = hsrn_pkg::mag(sum1);
        if ((l1_reg > 0 && k1_reg > 0) || (l1_reg < 0 && k1_reg < 0))
        begin
            ring_c = ms;
        end
        else
        begin
            ring_c = (ml > mk) ? ml : mk;
        end
        seg_c = '0;
        if (ms == ring_c && k1_reg != 0)
        begin
            seg_c = seg_c + 3'd1;
        end
        if (mk == ring_c && l1_reg != 0)
        begin
            seg_c = seg_c + 3'd2;
        end
        if (sum1 <= 0 && k1_reg < $signed({1'b0, ring_c}))
        begin
            seg_c = seg_c + 3'd3;
        end
        if (seg_c == 3'd0 || seg_c == 3'd3)
        begin
            along_c = ring_c - mk - 1'b1;
        end
        else if (seg_c == 3'd1 || seg_c == 3'd4)
        begin
            along_c = ring_c - ml - 1'b1;
        end
        else
        begin
            along_c = ml - 1'b1;
        end
    end

    // Second half: 1 + 3r(r-1) + seg*r + along
    assign rc       = hsrn_pkg::CALC_W'(ring2_reg);
    assign rr       = rc * (rc - 1'b1);
    assign idx_calc = hsrn_pkg::CALC_W'(1) + (rr << 1) + rr
                    + hsrn_pkg::CALC_W'(seg2_reg) * rc
                    + hsrn_pkg::CALC_W'(along2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= busy_reg;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
            if (busy_reg && walk_last)
            begin
                busy_reg <= 1'b0;
            end
            else if (!busy_reg && q_valid)
            begin
                busy_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (busy_reg)
            begin
                l_reg <= l_step;
                k_reg <= k_step;
                if (side_end)
                begin
                    s_reg <= '0;
                    d_reg <= d_reg + 1'b1;
                end
                else
                begin
                    s_reg <= s_reg + 1'b1;
                end
            end
            else if (q_valid)
            begin
                l_reg   <= q_data.l + lev_c;
                k_reg   <= q_data.k - lev_c;
                lev_reg <= q_data.lev;
                s_reg   <= '0;
                d_reg   <= '0;
            end

            l1_reg    <= l_step;
            k1_reg    <= k_step;
            last1_reg <= walk_last;

            ring2_reg  <= ring_c;
            seg2_reg   <= seg_c;
            along2_reg <= along_c;
            zero2_reg  <= (l1_reg == 0) && (k1_reg == 0);
            last2_reg  <= last1_reg;

            out_reg.neighbor_index <= zero2_reg ? '0 : idx_calc[hsrn_pkg::NIDX_W-1:0];
            out_reg.last           <= last2_reg;
        end
    end

endmodule

>>> src/hex_spiral_ring_neighbors_unit.sv
// Channel   Ports                   Direction  Request
// ------    ---------------------   ---------  ------------------------------
// item      push, full, item        in         cell_index, ring_level
// result    empty, pop, result      out        neighbor_index, last
//
// Front decodes the center index: one ring per cycle, then one side per cycle, and then
// pushes it into the queue, waiting while that is full; invalid requests drop at once.
// Back loads a center from the queue, then walks its 6*ring_level cells one cell per cycle
// unless a result waits unpopped; stages: visited cell, ring/side/position, result.
// A two-entry queue sits between them, so the front can decode while the back walks.
// Reset clears control and front data only; low pop freezes the back while a result waits.
module hex_spiral_ring_neighbors_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  hsrn_pkg::req_t  item,
    output logic            empty,
    input  logic            pop,
    output hsrn_pkg::res_t  result
);

    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    hsrn_pkg::cmd_t  q_wdata;
    hsrn_pkg::cmd_t  q_rdata;

    hsrn_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    hsrn_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .valid   (q_valid),
        .rd_data (q_rdata)
    );

    hsrn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

>>> src/hsrn_checker.sv
module hsrn_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            push,
    input logic            full,
    input hsrn_pkg::req_t  item,
    input logic            empty,
    input logic            pop,
    input hsrn_pkg::res_t  result
);

    // a waiting result is not withdrawn
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before pop");

    // ... and does not change while it waits
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("waiting result changed");

    // nothing to deliver while held in reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result shown during reset");

    // every neighbor lies within the farthest reachable ring
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(result.neighbor_index) <= 32'(hsrn_pkg::NIDX_MAX)))
        else $error("neighbor index out of range");

    // a valid request that is taken makes the front busy in the next cycle
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && item.ring_level != '0
         && item.ring_level <= hsrn_pkg::LEV_W'(hsrn_pkg::MAX_LEVEL)
         && 32'(item.cell_index) <= 32'(hsrn_pkg::LIMIT)) |=> full)
        else $error("valid request did not occupy the front");

endmodule

bind hex_spiral_ring_neighbors_unit hsrn_checker u_hsrn_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

>>> tb/hex_spiral_ring_neighbors_unit_test.sv
`timescale 1ns / 1ps

module hex_spiral_ring_neighbors_unit_test;

    localparam int RANDOM_QUERIES = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int IDLE_LIMIT     = 4000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    hsrn_pkg::req_t item;
    logic empty;
    logic pop;
    hsrn_pkg::res_t result;

    // axial step per side of a ring walk
    int step_l [6] = '{0, -1, -1, 0, 1, 1};
    int step_k [6] = '{1, 1, 0, -1, -1, 0};

    hsrn_pkg::res_t neighbors_expected[$];
    int   mismatches   = 0;
    int   burst_left   = 0;
    int   hold_request = 0;
    int   idle_cycles  = 0;

    hex_spiral_ring_neighbors_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int abs_of(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void axial_of(input int idx, output int l, output int k);
        int n;
        int off;
        int seg;
        int p1;
        if (idx == 0)
        begin
            l = 0;
            k = 0;
            return;
        end
        n = 1;
        while (3 * n * (n + 1) < idx)
            n++;
        off = idx - 1 - 3 * n * (n - 1);
        seg = off / n;
        if (seg > 5)
            seg = 5;
        p1 = off % n + 1;
        l = n + p1 * step_l[seg];
        k = -n + p1 * step_k[seg];
        for (int i = 0; i < seg; i++)
        begin
            l += step_l[i] * n;
            k += step_k[i] * n;
        end
    endfunction

    function automatic int spiral_of(input int l, input int k);
        int ring;
        int sum;
        int seg;
        int along;
        if (l == 0 && k == 0)
            return 0;
        sum = l + k;
        seg = 0;
        if ((l > 0 && k > 0) || (l < 0 && k < 0))
            ring = abs_of(sum);
        else
            ring = (abs_of(l) > abs_of(k)) ? abs_of(l) : abs_of(k);
        if (abs_of(sum) == ring && k != 0)
            seg += 1;
        if (abs_of(k) == ring && l != 0)
            seg += 2;
        if (sum <= 0 && k < ring)
            seg += 3;
        if (seg == 0 || seg == 3)
            along = ring - abs_of(k) - 1;
        else if (seg == 1 || seg == 4)
            along = ring - abs_of(l) - 1;
        else
            along = abs_of(l) - 1;
        return 1 + 3 * ring * (ring - 1) + seg * ring + along;
    endfunction

    // queue up every neighbor index the walk around this center will emit
    function automatic void predict_ring(input hsrn_pkg::req_t r);
        int   idx;
        int   lev;
        int   l;
        int   k;
        int   n;
        hsrn_pkg::res_t e;
        idx = int'(r.cell_index);
        lev = int'(r.ring_level);
        if (lev == 0 || lev > hsrn_pkg::MAX_LEVEL || idx > hsrn_pkg::LIMIT)
            return;
        axial_of(idx, l, k);
        l += lev;
        k -= lev;
        n = 0;
        for (int d = 0; d < 6; d++)
        begin
            for (int s = 0; s < lev; s++)
            begin
                l += step_l[d];
                k += step_k[d];
                e.neighbor_index = hsrn_pkg::NIDX_W'(spiral_of(l, k));
                e.last = (n == 6 * lev - 1);
                neighbors_expected = {neighbors_expected, e};
                n++;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // one request; returns at the edge that took it, then maybe idles
    task automatic send_query(input int idx, input int lev);
        hsrn_pkg::req_t r;
        int   gap;
        r.cell_index = hsrn_pkg::IDX_W'(idx);
        r.ring_level = hsrn_pkg::LEV_W'(lev);
        push <= 1'b1;
        item <= r;
        do
            @(posedge clk);
        while (full);
        predict_ring(r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_all_results;
        push <= 1'b0;
        @(posedge clk);
        while (neighbors_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes;
        send_query(0, 1);
        send_query(0, hsrn_pkg::MAX_LEVEL);
        send_query(hsrn_pkg::LIMIT, 1);
        send_query(hsrn_pkg::LIMIT, hsrn_pkg::MAX_LEVEL);
        send_query(12'hAAA, 5);
        send_query(12'h555, 6);
        send_query(1, 1);
    endtask

    task automatic test_ignored_requests;
        send_query(0, 0);
        send_query(7, 0);
        send_query(4095, 15);
        send_query(hsrn_pkg::LIMIT + 1, 3);
        send_query(200, hsrn_pkg::MAX_LEVEL + 1);
    endtask

    // first and last cell of several rings, where segment math turns over
    task automatic test_ring_boundaries;
        send_query(6, 2);
        send_query(7, 3);
        send_query(18, 4);
        send_query(19, 9);
        send_query(36, 7);
        send_query(37, 8);
        send_query(hsrn_pkg::LIMIT - 1, 2);
        send_query(1 + 3 * hsrn_pkg::MAX_RING * (hsrn_pkg::MAX_RING - 1), hsrn_pkg::MAX_LEVEL);
    endtask

    task automatic test_held_receiver;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_query($urandom_range(0, hsrn_pkg::LIMIT), $urandom_range(1, 3));
    endtask

    task automatic test_drain_pause;
        for (int i = 0; i < 4; i++)
            send_query($urandom_range(0, hsrn_pkg::LIMIT),
                       $urandom_range(1, hsrn_pkg::MAX_LEVEL));
        wait_all_results();
    endtask

    task automatic test_random_mix;
        int sent;
        int idx;
        int lev;
        int n;
        sent = 0;
        while (sent < RANDOM_QUERIES)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                idx = $urandom_range(0, 4095);
                lev = $urandom_range(1, hsrn_pkg::MAX_LEVEL);
                case ($urandom_range(0, 2))
                    0: lev = 0;
                    1: lev = $urandom_range(hsrn_pkg::MAX_LEVEL + 1, 15);
                    default: idx = $urandom_range(hsrn_pkg::LIMIT + 1, 4095);
                endcase
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        n = $urandom_range(1, hsrn_pkg::MAX_RING);
                        idx = ($urandom_range(0, 1) == 0) ? 3 * n * (n + 1)
                                                          : 1 + 3 * n * (n - 1);
                    end
                    1: idx = $urandom_range(0, 36);
                    default: idx = $urandom_range(0, hsrn_pkg::LIMIT);
                endcase
                lev = $urandom_range(1, hsrn_pkg::MAX_LEVEL);
                sent++;
                if (sent % 60 == 0)
                    wait_all_results();
            end
            send_query(idx, lev);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_ignored_requests();
        test_ring_boundaries();
        test_held_receiver();
        test_drain_pause();
        test_random_mix();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: rotating 16-bit stall pattern, drawn anew at random from four kinds
    initial
    begin : receiver
        logic [15:0] pattern;
        int          beat;
        int          hold_left;
        pop       = 1'b0;
        pattern   = 16'hFFFF;
        beat      = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (beat % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pattern = 16'hFFFF;
                    1: pattern = 16'($urandom);
                    2: pattern = 16'($urandom) & 16'($urandom);
                    default: pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= pattern[beat % 16];
            beat++;
        end
    end

    always @(posedge clk)
    begin : check_result
        hsrn_pkg::res_t want;
        if (pop && !empty)
        begin
            if (neighbors_expected.size() == 0)
                report_mismatch("unexpected neighbor_index", int'(result.neighbor_index), -1);
            else
            begin
                want = neighbors_expected.pop_front();
                if (result.neighbor_index !== want.neighbor_index)
                    report_mismatch("neighbor_index", int'(result.neighbor_index),
                                    int'(want.neighbor_index));
                if (result.last !== want.last)
                    report_mismatch("last", int'(result.last), int'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> filelist.f
src/hsrn_pkg.sv
src/hsrn_fifo.sv
src/hsrn_front.sv
src/hsrn_back.sv
src/hex_spiral_ring_neighbors_unit.sv
src/hsrn_checker.sv
tb/hex_spiral_ring_neighbors_unit_test.sv
